### src/fvws_pkg.sv
package fvws_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // floor(2^64 / (2*pi)), split into 32-bit halves
    localparam logic [31:0] INV_TWO_PI_LO = 32'h9391054A;
    localparam logic [31:0] INV_TWO_PI_HI = 32'h28BE60DB;

    localparam logic [31:0] QUARTER_TURN = 32'h40000000;

    // odd Taylor series of sin(pi/2*u)/u, Q30, lowest order first
    localparam logic [31:0] SIN_COEF [7] = '{
        32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995,
        32'd172272, 32'd3864, 32'd61
    };

    typedef enum logic [1:0] {
        CFG_W_IDENTITY   = 2'd0,
        CFG_W_SWIRL      = 2'd1,
        CFG_W_SPHERICAL  = 2'd2,
        CFG_W_SINUSOIDAL = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] src_x;
        logic signed [31:0] src_y;
    } point_t;

    typedef struct packed {
        logic signed [31:0] sum_x;
        logic signed [31:0] sum_y;
    } sum_t;

    // shift right, rounding toward zero
    function automatic logic signed [65:0] shr_tz(input logic signed [65:0] v,
                                                  input int unsigned sh);
        logic [65:0] m;
        m = v[65] ? 66'(-v) : 66'(v);
        m = m >> sh;
        return v[65] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        if (v < -66'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

### src/fvws_dly.sv
module fvws_dly #(
    parameter int W = 32,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] tap_reg [D];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int k = 1; k < D; k++)
            begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign q = tap_reg[D-1];

endmodule

### src/fvws_sin.sv
module fvws_sin (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        phase,
    output logic signed [31:0] sine
);

    import fvws_pkg::*;

    logic [30:0]        u_reg    [1:7];
    logic [31:0]        u2_reg   [1:6];
    logic               neg_reg  [1:7];
    logic [31:0]        acc_reg  [1:7];
    logic [31:0]        acc_next [1:7];
    logic [63:0]        prod     [2:7];
    logic signed [31:0] sin_reg;

    logic [30:0] u_in;
    logic [30:0] u_fold;
    logic [61:0] u_sq;
    logic [61:0] mag_full;
    logic [31:0] mag;

    always_comb
    begin
        u_in   = {1'b0, phase[29:0]};
        u_fold = phase[30] ? (31'h40000000 - u_in) : u_in;
        u_sq   = u_fold * u_fold;
        acc_next[1] = SIN_COEF[6];
        for (int k = 2; k <= 7; k++)
        begin
            prod[k]     = u2_reg[k-1] * acc_reg[k-1];
            acc_next[k] = SIN_COEF[7-k] - 32'(prod[k] >> 30);
        end
        mag_full = u_reg[7] * acc_reg[7][30:0];
        mag      = 32'(mag_full >> 30);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg[1]   <= u_fold;
            u2_reg[1]  <= 32'(u_sq >> 30);
            neg_reg[1] <= phase[31];
            for (int k = 2; k <= 7; k++)
            begin
                u_reg[k]   <= u_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
            for (int k = 2; k <= 6; k++)
            begin
                u2_reg[k] <= u2_reg[k-1];
            end
            for (int k = 1; k <= 7; k++)
            begin
                acc_reg[k] <= acc_next[k];
            end
            sin_reg <= neg_reg[7] ? -$signed(mag) : $signed(mag);
        end
    end

    assign sine = sin_reg;

endmodule

### src/fvws_div.sv
module fvws_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] num,
    input  logic [63:0] den,
    output logic [31:0] quo
);

    localparam int NW    = 32 + 2 * FRAC_BITS;
    localparam int STEPS = 32;

    logic [NW-1:0] dvd;
    logic [63:0]   rem_reg [1:STEPS];
    logic [63:0]   den_reg [1:STEPS];
    logic [31:0]   low_reg [1:STEPS];
    logic [31:0]   quo_reg [1:STEPS];

    assign dvd = NW'(num) << (2 * FRAC_BITS);

    for (genvar k = 1; k <= STEPS; k++)
    begin : g_step
        logic [63:0] rem_in;
        logic [63:0] den_in;
        logic [31:0] low_in;
        logic [31:0] quo_in;
        logic [64:0] trial;
        logic        fits;

        if (k == 1)
        begin : g_first
            assign rem_in = 64'(dvd[NW-1:32]);
            assign den_in = den;
            assign low_in = dvd[31:0];
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign low_in = low_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial = {rem_in, low_in[STEPS-k]};
        assign fits  = trial >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= fits ? 64'(trial - {1'b0, den_in}) : trial[63:0];
                den_reg[k] <= den_in;
                low_reg[k] <= low_in;
                quo_reg[k] <= {quo_in[30:0], fits};
            end
        end
    end

    assign quo = quo_reg[STEPS];

endmodule

### src/flame_variation_weighted_sum.sv
// channel  | dir | signals                              | payload
// point    | in  | point_valid, point_ready, point      | src_x, src_y (Q16.16)
// sum      | out | sum_valid, sum_ready, sum            | sum_x, sum_y (Q16.16, saturated)
// cfg      | in  | cfg_we, cfg_index, cfg_data          | four weights, write only
//
// One point per clock while no result is held on sum. A point passes three stages up
// to the denominator, the 32-step pipelined divider of the spherical term, then three
// stages of weighting and summing. The 8-stage sine units finish earlier.
// rst_n clears valid bits and loads the weights (identity 1.0, others 0).
// A result held on sum stalls every stage at once; nothing is dropped.
module flame_variation_weighted_sum #(
    parameter int FRAC_BITS = fvws_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             point_valid,
    output logic             point_ready,
    input  fvws_pkg::point_t point,
    output logic             sum_valid,
    input  logic             sum_ready,
    output fvws_pkg::sum_t   sum,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    import fvws_pkg::*;

    localparam int LAT = 38;

    logic            advance;
    logic [LAT:1]    vld_reg;

    logic signed [31:0] w_id_reg, w_sw_reg, w_sp_reg, w_sn_reg;

    // S1..S5
    logic signed [31:0] x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic [31:0]        ax1_reg, ay1_reg;
    logic [63:0]        sqx2_reg, sqy2_reg;
    logic [63:0]        kxl2_reg, kxh2_reg, kyl2_reg, kyh2_reg;
    logic [63:0]        r2_3_reg, den3_reg;
    logic [31:0]        phx3_reg, phy3_reg;
    logic [63:0]        pll4_reg, plh4_reg, phl4_reg, phh4_reg;
    logic [31:0]        phr5_reg;

    logic [95:0]        kx_full, ky_full;
    logic [127:0]       kr_full;

    // sine outputs
    logic signed [31:0] sr13, cr13, snx11, sny11;
    logic [1:0]         sgn11;

    logic signed [31:0] sntx12_reg, snty12_reg;
    logic [63:0]        snt35;

    logic [63:0]        xy13, xy35;
    logic signed [31:0] x13, y13, x35, y35;

    logic signed [63:0] pxs14_reg, pyc14_reg, pxc14_reg, pys14_reg;
    logic signed [31:0] swx15_reg, swy15_reg;
    logic [63:0]        sw35;

    logic [31:0]        qx35, qy35;
    logic signed [31:0] sphx35, sphy35;

    logic signed [63:0] wx36_reg [4];
    logic signed [63:0] wy36_reg [4];
    logic signed [65:0] tx37_reg [4];
    logic signed [65:0] ty37_reg [4];
    sum_t               sum_reg;

    assign advance     = !vld_reg[LAT] || sum_ready;
    assign point_ready = advance;
    assign sum_valid   = vld_reg[LAT];
    assign sum         = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[LAT-1:1], point_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_id_reg <= 32'(64'd1 << FRAC_BITS);
            w_sw_reg <= '0;
            w_sp_reg <= '0;
            w_sn_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_W_IDENTITY:   w_id_reg <= cfg_data;
                CFG_W_SWIRL:      w_sw_reg <= cfg_data;
                CFG_W_SPHERICAL:  w_sp_reg <= cfg_data;
                CFG_W_SINUSOIDAL: w_sn_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // phase products: magnitude times 1/(2*pi)
    always_comb
    begin
        kx_full = {32'd0, kxl2_reg} + {kxh2_reg, 32'd0};
        ky_full = {32'd0, kyl2_reg} + {kyh2_reg, 32'd0};
        kr_full = {64'd0, pll4_reg} + {32'd0, plh4_reg, 32'd0}
                + {32'd0, phl4_reg, 32'd0} + {phh4_reg, 64'd0};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x1_reg   <= point.src_x;
            y1_reg   <= point.src_y;
            ax1_reg  <= point.src_x[31] ? 32'(-point.src_x) : point.src_x;
            ay1_reg  <= point.src_y[31] ? 32'(-point.src_y) : point.src_y;

            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            sqx2_reg <= ax1_reg * ax1_reg;
            sqy2_reg <= ay1_reg * ay1_reg;
            kxl2_reg <= ax1_reg * INV_TWO_PI_LO;
            kxh2_reg <= ax1_reg * INV_TWO_PI_HI;
            kyl2_reg <= ay1_reg * INV_TWO_PI_LO;
            kyh2_reg <= ay1_reg * INV_TWO_PI_HI;

            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            r2_3_reg <= sqx2_reg + sqy2_reg;
            den3_reg <= sqx2_reg + sqy2_reg + (64'd1 << (2 * FRAC_BITS));
            phx3_reg <= kx_full[FRAC_BITS+32 +: 32];
            phy3_reg <= ky_full[FRAC_BITS+32 +: 32];

            pll4_reg <= r2_3_reg[31:0] * INV_TWO_PI_LO;
            plh4_reg <= r2_3_reg[31:0] * INV_TWO_PI_HI;
            phl4_reg <= r2_3_reg[63:32] * INV_TWO_PI_LO;
            phh4_reg <= r2_3_reg[63:32] * INV_TWO_PI_HI;

            phr5_reg <= kr_full[2*FRAC_BITS+32 +: 32];
        end
    end

    fvws_sin u_sin_r (.clk(clk), .en(advance), .phase(phr5_reg), .sine(sr13));
    fvws_sin u_cos_r (.clk(clk), .en(advance), .phase(phr5_reg + QUARTER_TURN), .sine(cr13));
    fvws_sin u_sin_x (.clk(clk), .en(advance), .phase(phx3_reg), .sine(snx11));
    fvws_sin u_sin_y (.clk(clk), .en(advance), .phase(phy3_reg), .sine(sny11));

    fvws_dly #(.W(2), .D(8)) u_dly_sgn (
        .clk(clk), .en(advance), .d({x3_reg[31], y3_reg[31]}), .q(sgn11)
    );

    // sinusoidal term
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sntx12_reg <= 32'(shr_tz(sgn11[1] ? -66'(snx11) : 66'(snx11), 30 - FRAC_BITS));
            snty12_reg <= 32'(shr_tz(sgn11[0] ? -66'(sny11) : 66'(sny11), 30 - FRAC_BITS));
        end
    end

    fvws_dly #(.W(64), .D(23)) u_dly_snt (
        .clk(clk), .en(advance), .d({sntx12_reg, snty12_reg}), .q(snt35)
    );

    fvws_dly #(.W(64), .D(10)) u_dly_xy13 (
        .clk(clk), .en(advance), .d({x3_reg, y3_reg}), .q(xy13)
    );

    assign x13 = $signed(xy13[63:32]);
    assign y13 = $signed(xy13[31:0]);

    // swirl term
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pxs14_reg <= x13 * sr13;
            pyc14_reg <= y13 * cr13;
            pxc14_reg <= x13 * cr13;
            pys14_reg <= y13 * sr13;
            swx15_reg <= sat32(shr_tz(66'(pxs14_reg) - 66'(pyc14_reg), 30));
            swy15_reg <= sat32(shr_tz(66'(pxc14_reg) + 66'(pys14_reg), 30));
        end
    end

    fvws_dly #(.W(64), .D(20)) u_dly_sw (
        .clk(clk), .en(advance), .d({swx15_reg, swy15_reg}), .q(sw35)
    );

    // spherical term
    fvws_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .clk(clk), .en(advance),
        .num(x3_reg[31] ? 32'(-x3_reg) : x3_reg), .den(den3_reg), .quo(qx35)
    );

    fvws_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .clk(clk), .en(advance),
        .num(y3_reg[31] ? 32'(-y3_reg) : y3_reg), .den(den3_reg), .quo(qy35)
    );

    fvws_dly #(.W(64), .D(32)) u_dly_xy35 (
        .clk(clk), .en(advance), .d({x3_reg, y3_reg}), .q(xy35)
    );

    assign x35    = $signed(xy35[63:32]);
    assign y35    = $signed(xy35[31:0]);
    assign sphx35 = x35[31] ? -$signed(qx35) : $signed(qx35);
    assign sphy35 = y35[31] ? -$signed(qy35) : $signed(qy35);

    // weighting and final sum
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            wx36_reg[0] <= w_id_reg * x35;
            wx36_reg[1] <= w_sw_reg * $signed(sw35[63:32]);
            wx36_reg[2] <= w_sp_reg * sphx35;
            wx36_reg[3] <= w_sn_reg * $signed(snt35[63:32]);
            wy36_reg[0] <= w_id_reg * y35;
            wy36_reg[1] <= w_sw_reg * $signed(sw35[31:0]);
            wy36_reg[2] <= w_sp_reg * sphy35;
            wy36_reg[3] <= w_sn_reg * $signed(snt35[31:0]);
            for (int k = 0; k < 4; k++)
            begin
                tx37_reg[k] <= shr_tz(66'(wx36_reg[k]), FRAC_BITS);
                ty37_reg[k] <= shr_tz(66'(wy36_reg[k]), FRAC_BITS);
            end
            sum_reg.sum_x <= sat32(tx37_reg[0] + tx37_reg[1] + tx37_reg[2] + tx37_reg[3]);
            sum_reg.sum_y <= sat32(ty37_reg[0] + ty37_reg[1] + ty37_reg[2] + ty37_reg[3]);
        end
    end

endmodule

### tb/flame_variation_weighted_sum_test.sv
module flame_variation_weighted_sum_test;
    import fvws_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int PIPE_LATENCY = 38;
    localparam int STALL_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        point_valid;
    logic        point_ready;
    point_t      point;
    logic        sum_valid;
    logic        sum_ready;
    sum_t        sum;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    logic [31:0] weight [4];
    sum_t        pending_sums [$];
    int          error_count;
    int          quiet_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          valid_held;

    flame_variation_weighted_sum dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .sum_valid   (sum_valid),
        .sum_ready   (sum_ready),
        .sum         (sum),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint shift_to_zero(longint v, int s);
        longint unsigned m;
        m = magnitude(v) >> s;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // angle in 2^-32 turn of a nonnegative value with fb fraction bits
    function automatic logic [31:0] turn_phase(longint unsigned v, int fb);
        logic [127:0] prod;
        prod = {64'd0, v} * {64'd0, INV_TWO_PI_HI, INV_TWO_PI_LO};
        prod = prod >> (fb + 32);
        return prod[31:0];
    endfunction

    function automatic longint sine_q30(logic [31:0] ph);
        longint unsigned u;
        longint unsigned u2;
        longint unsigned acc;
        u = {34'd0, ph[29:0]};
        if (ph[30])
        begin
            u = 64'h40000000 - u;
        end
        u2 = (u * u) >> 30;
        acc = 64'(SIN_COEF[6]);
        for (int i = 5; i >= 0; i--)
        begin
            acc = longint'(SIN_COEF[i]) - ((u2 * acc) >> 30);
        end
        acc = (u * acc) >> 30;
        return ph[31] ? -longint'(acc) : longint'(acc);
    endfunction

    function automatic longint sine_of_coord(longint c);
        longint s;
        s = sine_q30(turn_phase(magnitude(c), FB));
        if (c < 0)
        begin
            s = -s;
        end
        return shift_to_zero(s, 30 - FB);
    endfunction

    function automatic longint inverse_scaled(longint c, longint unsigned den);
        longint unsigned n;
        longint unsigned q;
        longint unsigned rem;
        bit carry;
        n = magnitude(c);
        q = n / den;
        rem = n % den;
        for (int i = 0; i < 2 * FB; i++)
        begin
            carry = rem[63];
            rem = rem << 1;
            q = q << 1;
            if (carry || rem >= den)
            begin
                rem = rem - den;
                q = q | 64'd1;
            end
        end
        return c < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint weigh(logic [31:0] w, longint v);
        return shift_to_zero(longint'($signed(w)) * v, FB);
    endfunction

    function automatic sum_t flame_sum(point_t p);
        longint x;
        longint y;
        longint unsigned r2;
        longint unsigned den;
        logic [31:0] ph;
        longint sr;
        longint cr;
        longint swx;
        longint swy;
        sum_t r;
        x = p.src_x;
        y = p.src_y;
        r2 = magnitude(x) * magnitude(x) + magnitude(y) * magnitude(y);
        den = r2 + (64'd1 << (2 * FB));
        ph = turn_phase(r2, 2 * FB);
        sr = sine_q30(ph);
        cr = sine_q30(ph + QUARTER_TURN);
        swx = clamp32(shift_to_zero(x * sr - y * cr, 30));
        swy = clamp32(shift_to_zero(x * cr + y * sr, 30));
        r.sum_x = 32'(clamp32(weigh(weight[CFG_W_IDENTITY], x) + weigh(weight[CFG_W_SWIRL], swx)
            + weigh(weight[CFG_W_SPHERICAL], inverse_scaled(x, den))
            + weigh(weight[CFG_W_SINUSOIDAL], sine_of_coord(x))));
        r.sum_y = 32'(clamp32(weigh(weight[CFG_W_IDENTITY], y) + weigh(weight[CFG_W_SWIRL], swy)
            + weigh(weight[CFG_W_SPHERICAL], inverse_scaled(y, den))
            + weigh(weight[CFG_W_SINUSOIDAL], sine_of_coord(y))));
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            sum_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        sum_t want;
        if ((point_valid && point_ready) || (sum_valid && sum_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (sum_valid && sum_ready)
        begin
            if (pending_sums.size() == 0)
            begin
                report_mismatch("unexpected transfer", sum.sum_x, 32'd0);
            end
            else
            begin
                want = pending_sums.pop_front();
                if (sum.sum_x !== want.sum_x)
                begin
                    report_mismatch("sum_x", sum.sum_x, want.sum_x);
                end
                if (sum.sum_y !== want.sum_y)
                begin
                    report_mismatch("sum_y", sum.sum_y, want.sum_y);
                end
            end
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_point(logic [31:0] x, logic [31:0] y);
        point_t p;
        p.src_x = x;
        p.src_y = y;
        point_valid <= 1'b1;
        point <= p;
        valid_held = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!point_ready);
        pending_sums.push_back(flame_sum(p));
        if ($urandom_range(99) < send_idle_pct)
        begin
            point_valid <= 1'b0;
            valid_held = 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // stop driving, wait for every sum, then let the pipeline empty
    task automatic drain;
        if (valid_held)
        begin
            point_valid <= 1'b0;
            valid_held = 1'b0;
        end
        while (pending_sums.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_weight(cfg_index_t idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        weight[idx] = value;
    endtask

    task automatic load_weights(logic [31:0] w_id, logic [31:0] w_sw,
                                logic [31:0] w_sp, logic [31:0] w_sn);
        write_weight(CFG_W_IDENTITY, w_id);
        write_weight(CFG_W_SWIRL, w_sw);
        write_weight(CFG_W_SPHERICAL, w_sp);
        write_weight(CFG_W_SINUSOIDAL, w_sn);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(32'h00100000) - 32'h00080000;
            2: return $urandom_range(32'h02000000) - 32'h01000000;
            default: return $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(3)
                                               : 32'h80000000 + $urandom_range(3);
        endcase
    endfunction

    function automatic logic [31:0] random_weight();
        case ($urandom_range(4))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'd0;
            3: return $urandom_range(32'h00080000) - 32'h00040000;
            default: return $urandom;
        endcase
    endfunction

    task automatic directed_points;
        send_point(32'h00000000, 32'h00000000);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h80000000);
        send_point(32'h80000000, 32'h7FFFFFFF);
        send_point(32'h00000001, 32'hFFFFFFFF);
        send_point(32'h00010000, 32'h00000000);
        send_point(32'h0003243F, 32'hFFFCDBC1);
        send_point(32'hFFFF0000, 32'h00019220);
        send_point(32'h00B504F3, 32'hFF4AFB0D);
        send_point(32'h55555555, 32'hAAAAAAAA);
    endtask

    task automatic test_reset_weights;
        directed_points();
        drain();
    endtask

    task automatic test_each_variation;
        load_weights(32'h00008000, 32'h7FFFFFFF, 32'h80000000, 32'h00030000);
        directed_points();
        drain();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                drain();
                load_weights(random_weight(), random_weight(), random_weight(),
                             random_weight());
            end
            send_point(random_coord(), random_coord());
        end
        drain();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        point_valid <= 1'b0;
        point <= '0;
        sum_ready <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_W_IDENTITY;
        cfg_data <= '0;
        error_count = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        valid_held = 1'b0;
        weight[CFG_W_IDENTITY] = 32'd1 << FB;
        weight[CFG_W_SWIRL] = 32'd0;
        weight[CFG_W_SPHERICAL] = 32'd0;
        weight[CFG_W_SINUSOIDAL] = 32'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_weights();
        test_each_variation();
        test_random_phase(0, 0, 200);
        test_random_phase(73, 0, 200);
        test_random_phase(0, 73, 200);
        test_random_phase(23, 23, 200);

        if (error_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
